// ----- rtl/hmlp_pkg.sv -----
// ============================================================================
// hmlp_pkg
// Shared constants and types for the linear-probing hash map: slot layout,
// memory write port, result bundle and operation codes.
// ============================================================================
package hmlp_pkg;

   // Store geometry.
   localparam int CAPACITY    = 1024;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;

   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam bit CAP_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

   // Port field widths.
   localparam int OP_W    = 2;
   localparam int FIELD_W = 32;
   localparam int HASH_W  = 32;
   localparam int LIMIT_W = 10;
   localparam int USED_W  = 11;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(768);

   // Start index reduction for a capacity that is not a power of two:
   // hash bits are folded in a few at a time.
   localparam int MOD_DIGITS = 4;
   localparam int MOD_STEPS  = HASH_W / MOD_DIGITS;
   localparam int MOD_STEP_W = $clog2(MOD_STEPS);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic                   tomb;
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
   } slot_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      slot_type         data;
   } ram_wr_type;

   typedef struct packed {
      logic               hit;
      logic [FIELD_W-1:0] value_out;
      logic               full_res;
      logic [USED_W-1:0]  used_count;
   } res_type;

endpackage

// ----- rtl/hash_map_linear_probe.sv -----
// ============================================================================
// hash_map_linear_probe
// Open-addressing key-to-value map with linear probing and tombstones.
// ============================================================================
// After reset the block sweeps the slot store clear, one slot per cycle, over
// all CAPACITY (1024) slots; req_stall stays high during that sweep. Each item
// then carries a nonzero key token and a precomputed hash; probing starts at
// hash mod CAPACITY and reads one slot per cycle from a single-port-read
// memory, probing 1 to CAPACITY slots per item. Items with a zero key or an
// unused op code skip the probe and go straight to the result. When CAPACITY
// is not a power of two, the hash is first reduced to a start slot in the
// S_MOD and S_START states before probing. Items are
// handled one at a time; a finished result sits in the output register so
// the next item can be taken while the result waits on rsp_stall. The used
// count covers live slots and tombstones and only falls at reset; an insert
// that needs a fresh empty slot when the count would pass load_limit is
// refused with rsp_full_res. load_limit is written through csr_wr_en and
// csr_wr_data and should only change while the block is idle.
// ============================================================================
module hash_map_linear_probe
   import hmlp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OP_W-1:0]    req_op,
   input  logic [FIELD_W-1:0] req_key,
   input  logic [HASH_W-1:0]  req_key_hash,
   input  logic [FIELD_W-1:0] req_value_in,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [FIELD_W-1:0] rsp_value_out,
   output logic               rsp_full_res,
   output logic [USED_W-1:0]  rsp_used_count,

   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   logic [LIMIT_W-1:0] load_limit_ff;
   logic               in_ready;
   slot_type           rd_data;
   logic [IDX_W-1:0]   rd_addr;
   ram_wr_type         wr;
   logic               res_valid;
   logic               res_take;
   res_type            res;
   logic               rsp_valid_ff, rsp_valid_in;
   res_type            rsp_ff;

   // Load limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         load_limit_ff <= csr_wr_data;
      end
   end

   assign req_stall = !in_ready;

   hmlp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .load_limit  (load_limit_ff),
      .in_valid    (req_valid),
      .in_ready    (in_ready),
      .in_op       (req_op),
      .in_key      (req_key),
      .in_key_hash (req_key_hash),
      .in_value    (req_value_in),
      .rd_data     (rd_data),
      .rd_addr     (rd_addr),
      .wr          (wr),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res         (res)
   );

   hmlp_slot_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The output register takes a result whenever it is empty or its item is
   // leaving in the same cycle.
   assign res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_ff.hit;
   assign rsp_value_out  = rsp_ff.value_out;
   assign rsp_full_res   = rsp_ff.full_res;
   assign rsp_used_count = rsp_ff.used_count;

endmodule

// ----- rtl/hmlp_slot_ram.sv -----
// ============================================================================
// hmlp_slot_ram
// Slot store: one write port and one read port, read data registered.
// ============================================================================
module hmlp_slot_ram
   import hmlp_pkg::*;
(
   input  logic             clock,
   input  ram_wr_type       wr,
   input  logic [IDX_W-1:0] rd_addr,
   output slot_type         rd_data
);

   slot_type mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/hmlp_ctrl.sv -----
// ============================================================================
// hmlp_ctrl
// Probe sequencer: clears the store after reset, walks the probe chain one
// slot per cycle, applies the operation and holds the result for pickup.
// ============================================================================
module hmlp_ctrl
   import hmlp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [LIMIT_W-1:0] load_limit,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [OP_W-1:0]    in_op,
   input  logic [FIELD_W-1:0] in_key,
   input  logic [HASH_W-1:0]  in_key_hash,
   input  logic [FIELD_W-1:0] in_value,
   input  slot_type           rd_data,
   output logic [IDX_W-1:0]   rd_addr,
   output ram_wr_type         wr,
   output logic               res_valid,
   input  logic               res_take,
   output res_type            res
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_START,
      S_PROBE,
      S_DONE
   } state_type;

   localparam int CMP_W = (CNT_W + 1 > LIMIT_W) ? CNT_W + 1 : LIMIT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   // Folds MOD_DIGITS hash bits into a remainder below CAPACITY.
   function automatic logic [IDX_W-1:0] mod_fold(input logic [IDX_W-1:0] rem,
                                                 input logic [MOD_DIGITS-1:0] dig);
      logic [IDX_W:0] r;
      r = {1'b0, rem};
      for (int i = MOD_DIGITS - 1; i >= 0; i--) begin
         r = {r[IDX_W-1:0], dig[i]};
         if (r >= (IDX_W + 1)'(CAPACITY)) begin
            r = r - (IDX_W + 1)'(CAPACITY);
         end
      end
      return r[IDX_W-1:0];
   endfunction

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic [IDX_W-1:0]       n_ff, n_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [HASH_W-1:0]      hash_ff, hash_in;
   logic [IDX_W-1:0]       rem_ff, rem_in;
   logic [MOD_STEP_W-1:0]  step_ff, step_in;
   logic                   tomb_seen_ff, tomb_seen_in;
   logic [IDX_W-1:0]       tomb_idx_ff, tomb_idx_in;
   logic [CNT_W-1:0]       used_ff, used_in;
   res_type                res_ff, res_in;

   logic [IDX_W-1:0]       next_idx;
   logic                   is_empty, is_tomb, is_match, is_last;
   logic                   done, found, have_slot, slot_is_tomb;
   logic [IDX_W-1:0]       slot_addr;
   logic                   over_limit;
   logic [KEY_WIDTH-1:0]   in_key_cut;

   assign next_idx   = (cur_ff == LAST_IDX) ? '0 : cur_ff + 1'b1;
   assign is_empty   = (rd_data.key == '0) && !rd_data.tomb;
   assign is_tomb    = (rd_data.key == '0) && rd_data.tomb;
   assign is_match   = (rd_data.key == key_ff);
   assign is_last    = (n_ff == LAST_IDX);
   assign over_limit = (CMP_W'(used_ff) + CMP_W'(1)) > CMP_W'(load_limit);
   assign in_key_cut = KEY_WIDTH'(in_key);

   assign in_ready  = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   // Probe outcome for the slot whose data is on the read port.
   always_comb begin
      done         = 1'b0;
      found        = 1'b0;
      have_slot    = 1'b0;
      slot_is_tomb = 1'b0;
      slot_addr    = cur_ff;
      if (is_match) begin
         done  = 1'b1;
         found = 1'b1;
      end else if (is_empty) begin
         done         = 1'b1;
         have_slot    = 1'b1;
         slot_is_tomb = tomb_seen_ff;
         slot_addr    = tomb_seen_ff ? tomb_idx_ff : cur_ff;
      end else if (is_last) begin
         done         = 1'b1;
         have_slot    = tomb_seen_ff || is_tomb;
         slot_is_tomb = 1'b1;
         slot_addr    = tomb_seen_ff ? tomb_idx_ff : cur_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      n_in         = n_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      hash_in      = hash_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      tomb_seen_in = tomb_seen_ff;
      tomb_idx_in  = tomb_idx_ff;
      used_in      = used_ff;
      res_in       = res_ff;
      rd_addr      = next_idx;
      wr           = '0;

      case (state_ff)
         S_CLEAR: begin
            wr.en    = 1'b1;
            wr.addr  = cur_ff;
            cur_in   = next_idx;
            if (cur_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (in_valid) begin
               op_in        = in_op;
               key_in       = in_key_cut;
               val_in       = VALUE_WIDTH'(in_value);
               hash_in      = in_key_hash;
               tomb_seen_in = 1'b0;
               n_in         = '0;
               if (in_key_cut == '0 ||
                   (in_op != OP_LOOKUP && in_op != OP_INSERT && in_op != OP_REMOVE)) begin
                  res_in   = '{hit: 1'b0, value_out: '0, full_res: 1'b0,
                               used_count: USED_W'(used_ff)};
                  state_in = S_DONE;
               end else if (CAP_POW2) begin
                  rd_addr  = in_key_hash[IDX_W-1:0];
                  cur_in   = in_key_hash[IDX_W-1:0];
                  state_in = S_PROBE;
               end else begin
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            rem_in  = mod_fold(rem_ff, hash_ff[HASH_W-1 -: MOD_DIGITS]);
            hash_in = hash_ff << MOD_DIGITS;
            step_in = step_ff + 1'b1;
            if (step_ff == MOD_STEP_W'(MOD_STEPS - 1)) begin
               state_in = S_START;
            end
         end
         S_START: begin
            rd_addr  = rem_ff;
            cur_in   = rem_ff;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            cur_in = next_idx;
            n_in   = n_ff + 1'b1;
            if (is_tomb && !tomb_seen_ff) begin
               tomb_seen_in = 1'b1;
               tomb_idx_in  = cur_ff;
            end
            if (done) begin
               res_in.hit       = found;
               res_in.value_out = '0;
               res_in.full_res  = 1'b0;
               case (op_ff)
                  OP_LOOKUP: begin
                     if (found) begin
                        res_in.value_out = FIELD_W'(rd_data.value);
                     end
                  end
                  OP_INSERT: begin
                     if (found) begin
                        wr = '{en: 1'b1, addr: cur_ff,
                               data: '{tomb: 1'b0, key: key_ff, value: val_ff}};
                     end else if (!have_slot) begin
                        res_in.full_res = 1'b1;
                     end else if (slot_is_tomb) begin
                        wr = '{en: 1'b1, addr: slot_addr,
                               data: '{tomb: 1'b0, key: key_ff, value: val_ff}};
                     end else if (over_limit) begin
                        res_in.full_res = 1'b1;
                     end else begin
                        wr = '{en: 1'b1, addr: slot_addr,
                               data: '{tomb: 1'b0, key: key_ff, value: val_ff}};
                        used_in = used_ff + 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (found) begin
                        wr = '{en: 1'b1, addr: cur_ff,
                               data: '{tomb: 1'b1, key: '0, value: '0}};
                     end
                  end
                  default: begin
                  end
               endcase
               res_in.used_count = USED_W'(used_in);
               state_in          = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cur_ff   <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         used_ff  <= used_in;
      end
      n_ff         <= n_in;
      op_ff        <= op_in;
      key_ff       <= key_in;
      val_ff       <= val_in;
      hash_ff      <= hash_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      tomb_seen_ff <= tomb_seen_in;
      tomb_idx_ff  <= tomb_idx_in;
      res_ff       <= res_in;
   end

   // The used count only ever moves up by one.
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) |-> (used_ff == $past(used_ff) + 1'b1))
      else $error("used count moved by other than one");

   // A new slot is counted only when a live key is written.
   a_used_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE && used_in != used_ff) |->
      (wr.en && !wr.data.tomb && wr.data.key != '0))
      else $error("used count rose without a live key write");

   // Outside the clearing sweep, the store is written only as a probe ends.
   a_write_end: assert property (@(posedge clock) disable iff (reset)
      (wr.en && state_ff != S_CLEAR) |=> (state_ff == S_DONE))
      else $error("slot write outside probe end");

   // Only an insert can be refused.
   a_full_insert: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ff.full_res) |-> (op_ff == OP_INSERT))
      else $error("full flag on an operation other than insert");

endmodule
